[sv/psg_pkg.sv]
// ----------------------------------------------------------------------------
// psg_pkg
// Shared widths and constants for the trial-division prime generator.
// ----------------------------------------------------------------------------
package psg_pkg;
  localparam int unsigned MAX_PRIMES = 1024;
  localparam int unsigned VAL_W      = 20;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned ADDR_W     = $clog2(MAX_PRIMES);
  localparam int unsigned FOUND_W    = $clog2(MAX_PRIMES + 1);
  localparam int unsigned SQ_W       = 2 * VAL_W;

  // Divider request and response.
  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] dividend;
    logic [VAL_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic zero_rem;
  } div_rsp_t;
endpackage

[sv/psg_ram.sv]
// ----------------------------------------------------------------------------
// psg_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module psg_ram #(
  parameter int unsigned WIDTH = 20,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one entry per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[sv/psg_div.sv]
// ----------------------------------------------------------------------------
// psg_div
// Bit-serial restoring remainder unit: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psg_div (
  input  logic               clk,
  input  logic               rst,
  input  psg_pkg::div_req_t  req,
  output psg_pkg::div_rsp_t  rsp
);
  logic [psg_pkg::VAL_W-1:0]         dend;
  logic [psg_pkg::VAL_W-1:0]         dsor;
  logic [psg_pkg::VAL_W:0]           rem;
  logic [$clog2(psg_pkg::VAL_W)-1:0] cnt;
  logic                              busy;
  logic                              done;
  logic [psg_pkg::VAL_W:0]           shifted;
  logic [psg_pkg::VAL_W:0]           diff;

  assign shifted = {rem[psg_pkg::VAL_W-1:0], dend[psg_pkg::VAL_W-1]};
  assign diff    = shifted - {1'b0, dsor};

  // Shift one dividend bit in and subtract where it fits.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        dend <= req.dividend;
        dsor <= req.divisor;
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        dend <= {dend[psg_pkg::VAL_W-2:0], 1'b0};
        rem  <= diff[psg_pkg::VAL_W] ? shifted : diff;
        cnt  <= cnt + 1'b1;
        if (cnt == ($clog2(psg_pkg::VAL_W))'(psg_pkg::VAL_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.zero_rem = (rem == '0);
endmodule

[sv/prime_sequence_generator_core.sv]
// ----------------------------------------------------------------------------
// prime_sequence_generator_core
// Order: prime 2 or a done reply is answered straight from idle; otherwise
// each stored prime tried passes a table read, a square, a serial remainder
// and its done cycle, repeated for each odd candidate until one is prime.
// Requests: one at a time; the remainder unit sets the rate.
// Reset: synchronous; sequence restarts at 2, prime_count returns to 1024.
// ----------------------------------------------------------------------------
module prime_sequence_generator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [19:0] prime_value,
  output logic [9:0]  prime_index,
  output logic        done_res
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_WAIT = 3'd2;
  localparam logic [2:0] ST_SQR  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_WR   = 3'd5;

  logic [2:0]                    state;
  logic [psg_pkg::CNT_W-1:0]     prime_count;
  logic [psg_pkg::FOUND_W-1:0]   primes_found;
  logic [psg_pkg::VAL_W:0]       cand;
  logic [psg_pkg::FOUND_W-1:0]   j;
  logic [psg_pkg::VAL_W-1:0]     p;
  logic [psg_pkg::SQ_W-1:0]      psq;
  logic                          out_full;
  logic                          ram_we;
  logic [psg_pkg::ADDR_W-1:0]    ram_addr;
  logic [psg_pkg::VAL_W-1:0]     ram_wdata;
  logic [psg_pkg::VAL_W-1:0]     ram_rdata;
  psg_pkg::div_req_t             dreq;
  psg_pkg::div_rsp_t             drsp;
  logic [psg_pkg::FOUND_W-1:0]   limit;
  logic [psg_pkg::FOUND_W-1:0]   found_now;

  // Saturate the count at the table size.
  assign limit = (prime_count > psg_pkg::CNT_W'(psg_pkg::MAX_PRIMES))
               ? psg_pkg::FOUND_W'(psg_pkg::MAX_PRIMES)
               : psg_pkg::FOUND_W'(prime_count);
  assign found_now = restart ? '0 : primes_found;

  assign cfg_ready = (state == ST_IDLE) && !out_full;
  assign in_ready  = (state == ST_IDLE) && !out_full;
  assign out_valid = out_full;

  assign ram_addr  = (state == ST_IDLE) ? psg_pkg::ADDR_W'(found_now) :
                     (state == ST_WR)   ? psg_pkg::ADDR_W'(primes_found) :
                                          psg_pkg::ADDR_W'(j);
  assign ram_we    = ((state == ST_IDLE) && in_valid && in_ready &&
                      (found_now < limit) && (found_now == '0)) ||
                     (state == ST_WR);
  assign ram_wdata = (state == ST_WR) ? cand[psg_pkg::VAL_W-1:0]
                                      : psg_pkg::VAL_W'(2);
  // In ST_WR the address must be primes_found.
  psg_ram #(.WIDTH(psg_pkg::VAL_W), .DEPTH(psg_pkg::MAX_PRIMES)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  assign dreq.start    = (state == ST_SQR) &&
                         !(psq > psg_pkg::SQ_W'(cand[psg_pkg::VAL_W-1:0]));
  assign dreq.dividend = cand[psg_pkg::VAL_W-1:0];
  assign dreq.divisor  = p;
  psg_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // Sequence the trial division.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      prime_count  <= psg_pkg::CNT_W'(psg_pkg::MAX_PRIMES);
      primes_found <= '0;
      cand         <= (psg_pkg::VAL_W+1)'(3);
      out_full     <= 1'b0;
    end else begin
      if (out_full && out_ready) begin
        out_full <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            prime_count <= cfg_data;
          end
          if (in_valid && in_ready) begin
            if (restart) begin
              primes_found <= '0;
              cand         <= (psg_pkg::VAL_W+1)'(3);
            end
            if (found_now >= limit) begin
              prime_value <= '0; prime_index <= '0; done_res <= 1'b1;
              out_full    <= 1'b1;
            end else if (found_now == '0) begin
              primes_found <= psg_pkg::FOUND_W'(1);
              cand         <= (psg_pkg::VAL_W+1)'(3);
              prime_value  <= psg_pkg::VAL_W'(2);
              prime_index  <= '0; done_res <= 1'b0;
              out_full     <= 1'b1;
            end else if (cand[psg_pkg::VAL_W]) begin
              prime_value <= '0; prime_index <= '0; done_res <= 1'b1;
              out_full    <= 1'b1;
            end else begin
              j     <= '0;
              state <= ST_READ;
            end
          end
        end
        ST_READ: begin
          // Candidate survived every stored prime: it is prime.
          if (j >= primes_found) begin
            state <= ST_WR;
          end else begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          p     <= ram_rdata;
          psq   <= ram_rdata * ram_rdata;
          state <= ST_SQR;
        end
        ST_SQR: begin
          if (psq > psg_pkg::SQ_W'(cand[psg_pkg::VAL_W-1:0])) begin
            state <= ST_WR;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (drsp.done) begin
            if (drsp.zero_rem) begin
              // Composite: try the next odd candidate from the first prime.
              if (cand + (psg_pkg::VAL_W+1)'(2) > (psg_pkg::VAL_W+1)'(20'hFFFFF)) begin
                prime_value <= '0; prime_index <= '0; done_res <= 1'b1;
                out_full    <= 1'b1;
                state       <= ST_IDLE;
              end else begin
                cand  <= cand + (psg_pkg::VAL_W+1)'(2);
                j     <= '0;
                state <= ST_READ;
              end
            end else begin
              j     <= j + 1'b1;
              state <= ST_READ;
            end
          end
        end
        ST_WR: begin
          prime_value  <= cand[psg_pkg::VAL_W-1:0];
          prime_index  <= primes_found[psg_pkg::IDX_W-1:0];
          done_res     <= 1'b0;
          out_full     <= 1'b1;
          primes_found <= primes_found + 1'b1;
          cand         <= cand + (psg_pkg::VAL_W+1)'(2);
          state        <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
